/* rtl/apnc_pkg.sv */
// Shared types and constants for the archive path name checker.
// No dependencies; used by apnc_path_check, the top level and the checker.
`default_nettype none

package apnc_pkg;

    // Counter widths and saturation values
    localparam int                  CNT_W         = 11;
    localparam logic [CNT_W-1:0]    CNT_MAX       = 11'h7FF;
    localparam int                  SEG_LEN_W     = 2;
    localparam logic [SEG_LEN_W-1:0] SEG_LEN_MAX  = 2'd3;

    // Defaults
    localparam int                  MAX_NAME_LEN_DEF = 1024;
    localparam logic [CNT_W-1:0]    MAX_DEPTH_RST    = 11'd32;

    // Byte codes
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One result item
    typedef struct packed {
        logic [7:0] folded_byte;
        logic       path_ok;
        logic       is_directory;
        logic       name_done;
    } apnc_result_t;

    // Map A-Z to a-z, pass every other byte
    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/archive_path_name_checker.sv */
// An input transfer passes through the input register, then the result register.
// Throughput: one byte per cycle while m_tready does not stall the result; the
// per-name flags and counters update in the single compute stage between the
// input register and the result register. Reset (aresetn low, synchronous)
// empties both stages, clears the name state and sets max_depth to 32.
// Top level of the archive path name checker; depends on apnc_pkg, apnc_path_check.
`default_nettype none

module archive_path_name_checker #(
    parameter int MAX_NAME_LEN = apnc_pkg::MAX_NAME_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,   // max_depth
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] path_byte
    input  wire logic        s_tlast,       // name_end
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,       // [7:0] folded_byte
    output logic [1:0]       m_tuser,       // [0] path_ok, [1] is_directory
    output logic             m_tlast        // name_done
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    apnc_pkg::apnc_result_t out_reg;
    apnc_pkg::apnc_result_t result;

    logic advance;

    // Move the input stage forward when the result stage is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    apnc_path_check #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .byte_in     (in_byte_reg),
        .last_in     (in_last_reg),
        .result      (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.folded_byte;
    assign m_tuser  = {out_reg.is_directory, out_reg.path_ok};
    assign m_tlast  = out_reg.name_done;

endmodule

`default_nettype wire

/* rtl/apnc_path_check.sv */
// Per-name path state and verdict logic for the archive path name checker.
// Depends on apnc_pkg. State advances on each step; result is combinational.
`default_nettype none

module apnc_path_check #(
    parameter int MAX_NAME_LEN = apnc_pkg::MAX_NAME_LEN_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [apnc_pkg::CNT_W-1:0]  cfg_wr_data,
    input  wire logic                        step,
    input  wire logic [7:0]                  byte_in,
    input  wire logic                        last_in,
    output apnc_pkg::apnc_result_t           result
);

    localparam logic [apnc_pkg::CNT_W-1:0] MaxLen = apnc_pkg::CNT_W'(MAX_NAME_LEN);

    logic [apnc_pkg::CNT_W-1:0]     max_depth_reg;
    logic                           reject_seen_reg, reject_seen_next;
    logic [apnc_pkg::CNT_W-1:0]     name_length_reg, name_length_next;
    logic [apnc_pkg::SEG_LEN_W-1:0] seg_len_reg, seg_len_next;
    logic                           first_dot_reg, first_dot_next;
    logic                           second_dot_reg, second_dot_next;
    logic [apnc_pkg::CNT_W-1:0]     seg_count_reg, seg_count_next;

    logic bad;
    logic slash;
    logic dot;
    logic illegal;
    logic bad_segment;
    logic dot_tail;
    logic ok;

    // Evaluate one byte against the running name state
    always_comb begin
        slash   = (byte_in == apnc_pkg::CHAR_SLASH);
        dot     = (byte_in == apnc_pkg::CHAR_DOT);
        illegal = (byte_in < apnc_pkg::CTRL_LIMIT) || (byte_in == apnc_pkg::CHAR_DEL) ||
                  (byte_in == apnc_pkg::CHAR_BSLASH) || (byte_in == apnc_pkg::CHAR_COLON) ||
                  byte_in[7];

        name_length_next = (name_length_reg != apnc_pkg::CNT_MAX) ?
                           name_length_reg + 1'b1 : apnc_pkg::CNT_MAX;

        bad = reject_seen_reg || illegal || (name_length_reg == '0 && slash) ||
              (name_length_next > MaxLen);

        bad_segment = (seg_len_reg == 2'd0) ||
                      (seg_len_reg == 2'd1 && first_dot_reg) ||
                      (seg_len_reg == 2'd2 && first_dot_reg && second_dot_reg);

        seg_count_next  = seg_count_reg;
        seg_len_next    = seg_len_reg;
        first_dot_next  = first_dot_reg;
        second_dot_next = second_dot_reg;

        if (slash) begin
            // Close the segment and open a new one
            if (seg_count_reg != apnc_pkg::CNT_MAX) begin
                seg_count_next = seg_count_reg + 1'b1;
            end
            bad = bad || bad_segment || (seg_count_next > max_depth_reg);
            seg_len_next    = '0;
            first_dot_next  = 1'b0;
            second_dot_next = 1'b0;
        end else begin
            if (seg_len_reg == 2'd0) begin
                first_dot_next = dot;
            end else if (seg_len_reg == 2'd1) begin
                second_dot_next = dot;
            end
            if (seg_len_reg != apnc_pkg::SEG_LEN_MAX) begin
                seg_len_next = seg_len_reg + 1'b1;
            end
        end

        reject_seen_next = bad;

        // Final segment "." or ".." rejects a name that ends without a slash
        dot_tail = (seg_len_next == 2'd1 && first_dot_next) ||
                   (seg_len_next == 2'd2 && first_dot_next && second_dot_next);
        if (slash) begin
            ok = !bad && (name_length_next > 11'd1);
        end else begin
            ok = !bad && !dot_tail;
        end

        result.folded_byte  = apnc_pkg::fold_byte(byte_in);
        result.path_ok      = last_in && ok;
        result.is_directory = last_in && ok && slash;
        result.name_done    = last_in;
    end

    // Hold the depth limit; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= apnc_pkg::MAX_DEPTH_RST;
        end else if (cfg_wr_en) begin
            max_depth_reg <= cfg_wr_data;
        end
    end

    // Advance name state per byte, clear after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_in)) begin
            reject_seen_reg <= 1'b0;
            name_length_reg <= '0;
            seg_len_reg     <= '0;
            first_dot_reg   <= 1'b0;
            second_dot_reg  <= 1'b0;
            seg_count_reg   <= apnc_pkg::CNT_W'(1);
        end else if (step) begin
            reject_seen_reg <= reject_seen_next;
            name_length_reg <= name_length_next;
            seg_len_reg     <= seg_len_next;
            first_dot_reg   <= first_dot_next;
            second_dot_reg  <= second_dot_next;
            seg_count_reg   <= seg_count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/apnc_checker.sv */
// Port-level assertions for archive_path_name_checker, bound to the top level.
// Depends on apnc_pkg for byte codes.
`default_nettype none

module apnc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // A stalled result transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("stalled result changed");

    // Verdict bits stay low except on the last byte of a name
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == 2'b00)
        else $error("verdict outside name end");

    // A directory mark only comes with an accepted path ending in a slash
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata == apnc_pkg::CHAR_SLASH)
        else $error("directory mark without accepted slash");

    // Folded bytes never carry an upper-case letter
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata >= apnc_pkg::CHAR_UPPER_A && m_tdata <= apnc_pkg::CHAR_UPPER_Z))
        else $error("upper-case byte passed");

    // An accepted path never ends in a forbidden byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata >= apnc_pkg::CTRL_LIMIT &&
                                   m_tdata != apnc_pkg::CHAR_DEL && !m_tdata[7] &&
                                   m_tdata != apnc_pkg::CHAR_BSLASH &&
                                   m_tdata != apnc_pkg::CHAR_COLON)
        else $error("accepted path ends in forbidden byte");

endmodule

bind archive_path_name_checker apnc_checker u_apnc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for archive_path_name_checker: streams path names byte by byte
// under random source gaps and sink stalls, and checks every result against a local model.
// Depends on apnc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int         MAX_NAME_LEN = 1024;
    localparam logic [7:0] HIGH_BYTE    = 8'h80;
    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam int         DRAIN_CYCLES = 6;

    typedef struct {
        logic [7:0] path_byte;
        logic       name_end;
    } path_item_t;

    // DUT connections; the ones the bench drives are known from time zero
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;      // [7:0] path_byte
    logic        s_tlast     = 1'b0;    // name_end
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;               // [7:0] folded_byte
    logic [1:0]  m_tuser;               // [0] path_ok, [1] is_directory
    logic        m_tlast;               // name_done

    // Stimulus and expected-result stores
    path_item_t             pending_q[$];
    logic [7:0]             name_buf[$];
    apnc_pkg::apnc_result_t verdict_q[$];
    int                     items_queued = 0;
    int                     error_count  = 0;
    int                     results_seen = 0;
    int                     cycle_count  = 0;

    // Local copy of the checker state and its register
    logic [apnc_pkg::CNT_W-1:0]     depth_limit = apnc_pkg::MAX_DEPTH_RST;
    logic                           name_reject = 1'b0;
    logic [apnc_pkg::CNT_W-1:0]     name_len    = '0;
    logic [apnc_pkg::SEG_LEN_W-1:0] seg_len     = '0;
    logic                           seg_dot1    = 1'b0;
    logic                           seg_dot2    = 1'b0;
    logic [apnc_pkg::CNT_W-1:0]     seg_count   = 11'd1;

    // Handshake bookkeeping
    logic                   src_taken = 1'b0;
    int                     src_gap   = 0;
    int                     src_calm  = 0;
    int                     snk_gap   = 0;
    int                     snk_calm  = 0;
    path_item_t             drive_item;
    apnc_pkg::apnc_result_t want;

    archive_path_name_checker #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance one byte through the path rules; returns the expected result
    function automatic apnc_pkg::apnc_result_t judge_byte(input logic [7:0] b,
                                                          input logic name_end);
        apnc_pkg::apnc_result_t     r;
        logic                       bad;
        logic                       slash;
        logic [apnc_pkg::CNT_W-1:0] len_next;
        bad      = name_reject;
        slash    = (b == apnc_pkg::CHAR_SLASH);
        len_next = (name_len == apnc_pkg::CNT_MAX) ? apnc_pkg::CNT_MAX : name_len + 1'b1;
        if (b < apnc_pkg::CTRL_LIMIT || b == apnc_pkg::CHAR_DEL ||
            b == apnc_pkg::CHAR_BSLASH || b == apnc_pkg::CHAR_COLON ||
            b >= HIGH_BYTE) begin
            bad = 1'b1;
        end
        if (name_len == '0 && slash) begin
            bad = 1'b1;
        end
        if (len_next > MAX_NAME_LEN) begin
            bad = 1'b1;
        end
        // A slash closes the current segment and opens the next
        if (slash) begin
            if (seg_len == 0 || (seg_len == 1 && seg_dot1) ||
                (seg_len == 2 && seg_dot1 && seg_dot2)) begin
                bad = 1'b1;
            end
            if (seg_count != apnc_pkg::CNT_MAX) begin
                seg_count = seg_count + 1'b1;
            end
            if (seg_count > depth_limit) begin
                bad = 1'b1;
            end
            seg_len  = '0;
            seg_dot1 = 1'b0;
            seg_dot2 = 1'b0;
        end else begin
            if (seg_len == 0) begin
                seg_dot1 = (b == apnc_pkg::CHAR_DOT);
            end else if (seg_len == 1) begin
                seg_dot2 = (b == apnc_pkg::CHAR_DOT);
            end
            if (seg_len != apnc_pkg::SEG_LEN_MAX) begin
                seg_len = seg_len + 1'b1;
            end
        end
        r.folded_byte  = (b >= apnc_pkg::CHAR_UPPER_A && b <= apnc_pkg::CHAR_UPPER_Z) ?
                         b + apnc_pkg::CASE_OFFSET : b;
        r.path_ok      = 1'b0;
        r.is_directory = 1'b0;
        r.name_done    = name_end;
        name_len       = len_next;
        name_reject    = bad;
        // Last byte: give the verdict and clear the per-name state
        if (name_end) begin
            if (slash) begin
                r.path_ok      = !bad && len_next > 1;
                r.is_directory = r.path_ok;
            end else begin
                r.path_ok = !bad && !(seg_len == 1 && seg_dot1) &&
                            !(seg_len == 2 && seg_dot1 && seg_dot2);
            end
            name_reject = 1'b0;
            name_len    = '0;
            seg_len     = '0;
            seg_dot1    = 1'b0;
            seg_dot2    = 1'b0;
            seg_count   = 11'd1;
        end
        return r;
    endfunction

    // Mostly no gap, some short, a few long; none during a calm stretch
    function automatic int pick_gap(input int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0 || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] legal_char();
        int         k;
        logic [7:0] c;
        k = $urandom_range(0, 9);
        if (k < 2) begin
            c = apnc_pkg::CHAR_DOT;
        end else if (k < 4) begin
            c = 8'($urandom_range(apnc_pkg::CHAR_UPPER_A, apnc_pkg::CHAR_UPPER_Z));
        end else if (k < 7) begin
            c = 8'($urandom_range(8'h61, 8'h7A));
        end else begin
            c = 8'($urandom_range(apnc_pkg::CTRL_LIMIT, 8'h7E));
            if (c == apnc_pkg::CHAR_SLASH || c == apnc_pkg::CHAR_BSLASH ||
                c == apnc_pkg::CHAR_COLON) begin
                c = 8'h5F;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] illegal_char();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, apnc_pkg::CTRL_LIMIT - 1));
            1: return apnc_pkg::CHAR_DEL;
            2: return apnc_pkg::CHAR_BSLASH;
            3: return apnc_pkg::CHAR_COLON;
            default: return 8'($urandom_range(HIGH_BYTE, 8'hFF));
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned exp_val);
        $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                 results_seen, field, got, exp_val);
        error_count++;
    endtask

    // Move the assembled name into the transfer queue, flag on its last byte
    task automatic send_name();
        path_item_t it;
        for (int i = 0; i < name_buf.size(); i++) begin
            it.path_byte = name_buf[i];
            it.name_end  = (i == name_buf.size() - 1);
            pending_q.insert(pending_q.size(), it);
        end
        items_queued += name_buf.size();
        name_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            name_buf.insert(name_buf.size(), s[i]);
        end
        send_name();
    endtask

    task automatic send_byte(input logic [7:0] b);
        name_buf.insert(name_buf.size(), b);
        send_name();
    endtask

    // Mostly well-formed paths with random content, the rest broken or noise
    task automatic send_random_name(input int depth_cap);
        int nseg;
        int kind;
        if ($urandom_range(0, 99) < 75) begin
            nseg = $urandom_range(1, depth_cap);
            for (int s = 0; s < nseg; s++) begin
                if (s > 0) begin
                    name_buf.insert(name_buf.size(), apnc_pkg::CHAR_SLASH);
                end
                kind = $urandom_range(0, 29);
                if (kind == 0) begin
                    name_buf.insert(name_buf.size(), apnc_pkg::CHAR_DOT);
                end else if (kind == 1) begin
                    name_buf.insert(name_buf.size(), apnc_pkg::CHAR_DOT);
                    name_buf.insert(name_buf.size(), apnc_pkg::CHAR_DOT);
                end else if (kind > 2) begin
                    repeat ($urandom_range(1, 5)) begin
                        name_buf.insert(name_buf.size(), legal_char());
                    end
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                name_buf.insert(name_buf.size(), apnc_pkg::CHAR_SLASH);
            end
            if (name_buf.size() > 0 && $urandom_range(0, 9) == 0) begin
                name_buf[$urandom_range(0, name_buf.size() - 1)] = illegal_char();
            end
            if ($urandom_range(0, 19) == 0) begin
                name_buf.push_front(apnc_pkg::CHAR_SLASH);
            end
        end else begin
            repeat ($urandom_range(1, 8)) begin
                name_buf.insert(name_buf.size(), ($urandom_range(0, 3) == 0) ?
                                apnc_pkg::CHAR_SLASH : 8'($urandom));
            end
        end
        send_name();
    endtask

    task automatic random_phase(input int budget, input int depth_cap);
        int start;
        start = items_queued;
        while (items_queued - start < budget) begin
            send_random_name(depth_cap);
        end
    endtask

    // Wait until every byte has gone in and every result has come out
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_depth(input logic [10:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Source side: hold until transfer, then wait out a gap and present the next byte
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !src_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                drive_item = pending_q.pop_front();
                s_tdata  <= drive_item.path_byte;
                s_tlast  <= drive_item.name_end;
                s_tvalid <= 1'b1;
                src_gap  = pick_gap(src_calm);
                if (src_calm > 0) begin
                    src_calm--;
                end else if ($urandom_range(0, 149) == 0) begin
                    src_calm = $urandom_range(40, 160);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: stall in random stretches
    always @(negedge aclk) begin
        if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            snk_gap  = pick_gap(snk_calm);
            if (snk_calm > 0) begin
                snk_calm--;
            end else if ($urandom_range(0, 149) == 0) begin
                snk_calm = $urandom_range(40, 160);
            end
        end
    end

    // Sample both channels and the register write at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                depth_limit = cfg_wr_data;
            end
            src_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                verdict_q.insert(verdict_q.size(), judge_byte(s_tdata, s_tlast));
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata !== want.folded_byte) begin
                        report_mismatch("folded_byte", m_tdata, want.folded_byte);
                    end
                    if (m_tuser[0] !== want.path_ok) begin
                        report_mismatch("path_ok", m_tuser[0], want.path_ok);
                    end
                    if (m_tuser[1] !== want.is_directory) begin
                        report_mismatch("is_directory", m_tuser[1], want.is_directory);
                    end
                    if (m_tlast !== want.name_done) begin
                        report_mismatch("name_done", m_tlast, want.name_done);
                    end
                end
                results_seen++;
            end
        end
    end

    // Guard against a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Reset, then the phases: directed names, then random names under several depths
    initial begin
        int depth_value;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_depth(11'd32);
        send_text("@AZ[");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(apnc_pkg::CTRL_LIMIT - 1);
        send_byte(apnc_pkg::CTRL_LIMIT);
        send_byte(8'h7E);
        send_byte(apnc_pkg::CHAR_DEL);
        send_byte(HIGH_BYTE);
        send_byte(apnc_pkg::CHAR_COLON);
        send_text("a\\");
        send_text("/");
        send_text(".");
        send_text("..");
        send_text("...");
        send_text("../");
        send_text("a/");
        send_text("a//b");
        wait_idle();

        // A depth of zero behaves like one
        write_depth(11'd0);
        send_text("a/b");
        send_text("a");
        random_phase(60, 3);
        wait_idle();

        write_depth(11'd1);
        random_phase(60, 3);
        wait_idle();

        write_depth(11'd2);
        random_phase(70, 4);
        wait_idle();

        // Depth of 1024: a name one byte over the length limit
        write_depth(11'd1024);
        repeat (MAX_NAME_LEN + 1) name_buf.insert(name_buf.size(), legal_char());
        send_name();
        random_phase(50, 10);
        wait_idle();

        depth_value = $urandom_range(3, 12);
        write_depth(11'(depth_value));
        random_phase(80, depth_value + 2);
        wait_idle();

        write_depth(11'($urandom_range(13, 1024)));
        random_phase(60, 10);
        wait_idle();

        write_depth(11'd32);
        random_phase(60, 10);
        wait_idle();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* archive_path_name_checker.f */
rtl/apnc_pkg.sv
rtl/apnc_path_check.sv
rtl/archive_path_name_checker.sv
rtl/apnc_checker.sv
sim/tb_top.sv
